// ===== src/brs_pkg.sv =====
package brs_pkg;

	localparam int MaxWidth    = 1024;
	localparam int MaxHeight   = 65535;
	localparam int StoreDepth  = 2 * MaxWidth + 1;
	localparam int AddrBits    = $clog2(StoreDepth);
	localparam int IdxBits     = 26;
	localparam int CntBits     = 27;

	localparam logic signed [63:0] Log2eQ30 = 64'sd1549082005;
	localparam logic signed [63:0] Ln2Q30   = 64'sd744261118;

	// configuration register indexes
	localparam logic [2:0] RegWidth  = 3'd0;
	localparam logic [2:0] RegHeight = 3'd1;
	localparam logic [2:0] RegCoefH  = 3'd2;
	localparam logic [2:0] RegCoefV  = 3'd3;
	localparam logic [2:0] RegSource = 3'd4;

	// input kinds
	localparam logic KindValue = 1'b0;
	localparam logic KindFlush = 1'b1;

	// 1/n! in Q30
	function automatic logic signed [63:0] inv_fact(input logic [3:0] n);
		logic signed [63:0] v;
		case (n)
			4'd0: v = 64'sd1073741824;
			4'd1: v = 64'sd1073741824;
			4'd2: v = 64'sd536870912;
			4'd3: v = 64'sd178956971;
			4'd4: v = 64'sd44739243;
			4'd5: v = 64'sd8947849;
			4'd6: v = 64'sd1491308;
			4'd7: v = 64'sd213044;
			4'd8: v = 64'sd26631;
			default: v = 64'sd0;
		endcase
		return v;
	endfunction

	// stencil job handed from front to back
	typedef struct packed {
		logic                  boundary;
		logic                  last;
		logic [IdxBits-1:0]    index;
		logic signed [31:0]    u;
		logic signed [31:0]    ul;
		logic signed [31:0]    ur;
		logic signed [31:0]    ut;
		logic signed [31:0]    ub;
	} job_t;

	// rounded scaling of a difference by an unsigned Q7.24 coefficient
	function automatic logic signed [63:0] scale_term(input logic signed [33:0] d,
			input logic [30:0] c);
		logic [33:0] m;
		logic [64:0] q;
		m = d[33] ? 34'(-d) : 34'(d);
		q = (65'(m) * 65'(c) + 65'(64'd1 << 23)) >> 24;
		return d[33] ? -64'(q) : 64'(q);
	endfunction

endpackage

// ===== src/bratu_residual_stencil_core.sv =====
// five-point bratu residual over a raster stream of signed q8.24 grid values
// s_axis: one transaction per grid value (tuser = 0) or flush tick (tuser = 1)
// m_axis: one transaction per grid point: residual, raster index, tlast on the
//   final point of the grid
// a point's result is produced with the input one row plus one value later;
//   after the grid is complete, one flush tick drains one pending point
// throughput: one input transaction per cycle while s_axis_tready is high; the line store has one write
//   port and is read at two addresses a cycle, the other taps come from registers
// the back end is a 14-stage exp and sum pipeline, fed through a 4-entry queue
// reset clears all counters and restores the register defaults; the line
//   store is not cleared and needs no clearing pass
// when m_axis stalls, the pipeline holds, the queue fills, and s_axis_tready
//   drops once the queue is full and the read stage holds a job
// configuration: write cfg_we with cfg_index and cfg_data while idle
module bratu_residual_stencil_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // grid_value
	input  logic        s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // residual, point_index, zero fill
	output logic        m_axis_tlast,   // last
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	logic [10:0] grid_width_q;
	logic [15:0] grid_height_q;
	logic [30:0] coef_h_q, coef_v_q, source_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= 11'd4;
			grid_height_q <= 16'd4;
			coef_h_q <= 31'd16777216;
			coef_v_q <= 31'd16777216;
			source_q <= 31'd11184811;
		end else if (cfg_we) begin
			case (cfg_index)
				brs_pkg::RegWidth:  grid_width_q <= cfg_data[10:0];
				brs_pkg::RegHeight: grid_height_q <= cfg_data[15:0];
				brs_pkg::RegCoefH:  coef_h_q <= cfg_data;
				brs_pkg::RegCoefV:  coef_v_q <= cfg_data;
				brs_pkg::RegSource: source_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic f_valid, f_ready, q_valid, q_ready;
	brs_pkg::job_t f_job, q_job;
	logic [31:0] res;
	logic [brs_pkg::IdxBits-1:0] idx;

	brs_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_kind(s_axis_tuser), .in_value(s_axis_tdata),
		.grid_width(grid_width_q), .grid_height(grid_height_q),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	brs_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
	);

	brs_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.coef_h(coef_h_q), .coef_v(coef_v_q), .source(source_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_residual(res), .out_index(idx), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, idx, res};

endmodule

// ===== src/brs_front.sv =====
// accepts the raster stream, keeps the line store, builds stencil jobs
module brs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   in_kind,
	input  logic [31:0]            in_value,
	input  logic [10:0]            grid_width,
	input  logic [15:0]            grid_height,
	output logic                   job_valid,
	input  logic                   job_ready,
	output brs_pkg::job_t          job
);

	logic [31:0] store_q [brs_pkg::StoreDepth];

	logic [10:0] w;
	logic [15:0] h;
	logic [brs_pkg::AddrBits-1:0] depth;
	logic [brs_pkg::CntBits-1:0] total;
	logic [brs_pkg::CntBits-1:0] input_count_q;
	logic [10:0] emit_column_q;
	logic [15:0] emit_row_q;
	logic [brs_pkg::AddrBits-1:0] wr_ptr_q, emit_ptr_q;
	logic [31:0] last_wr_q;

	// registered read stage
	logic        s1_valid_s1;
	logic [31:0] u_s1, ul_s1, ur_s1, ut_s1, ub_s1;
	logic        bnd_s1, last_s1;
	logic [brs_pkg::IdxBits-1:0] idx_s1;
	logic [brs_pkg::IdxBits-1:0] idx_q;

	logic fire, is_flush, emit, wr, wrap_rows, last_pt, bnd, row_zero;
	logic [brs_pkg::AddrBits-1:0] rd_a, rd_b;

	// clamped geometry
	always_comb begin
		w = (grid_width < 11'd3) ? 11'd3
			: (grid_width > 11'(brs_pkg::MaxWidth)) ? 11'(brs_pkg::MaxWidth) : grid_width;
		h = (grid_height < 16'd3) ? 16'd3 : grid_height;
		depth = brs_pkg::AddrBits'({w, 1'b1});
		total = brs_pkg::CntBits'(27'(w) * 27'(h));
	end

	assign in_ready = !s1_valid_s1 || job_ready;
	assign fire = in_valid && in_ready;
	assign wrap_rows = emit_row_q >= h;
	assign is_flush = (in_kind == brs_pkg::KindFlush);

	always_comb begin
		logic [brs_pkg::CntBits-1:0] cnt;
		cnt = wrap_rows ? '0 : input_count_q;
		if (!is_flush) begin
			wr = cnt < total;
			emit = wr && (cnt >= brs_pkg::CntBits'(w) + 1'b1);
		end else begin
			wr = 1'b0;
			emit = cnt >= total;
		end
	end

	// read addresses: right neighbor, and the entry below (the one being
	// overwritten now) or the center itself on the first row
	always_comb begin
		row_zero = (emit_row_q == 16'd0);
		rd_a = (emit_ptr_q == depth - 1'b1) ? '0 : emit_ptr_q + 1'b1;
		rd_b = row_zero ? emit_ptr_q : wr_ptr_q;
		bnd = (emit_column_q == 11'd0) || row_zero
			|| (emit_column_q >= w - 11'd1) || (emit_row_q >= h - 16'd1);
		last_pt = (emit_row_q == h - 16'd1) && (emit_column_q == w - 11'd1);
	end

	// line store and read stage; left tap and, past the first row, center tap slide
	// from the previous job, the upper tap is the value written just before
	always_ff @(posedge clk) begin
		if (fire && wr) begin
			store_q[wr_ptr_q] <= in_value;
			last_wr_q <= in_value;
		end
		if (fire && emit) begin
			u_s1  <= row_zero ? store_q[rd_b] : ur_s1;
			ul_s1 <= u_s1;
			ur_s1 <= store_q[rd_a];
			ub_s1 <= store_q[rd_b];
			ut_s1 <= last_wr_q;
			bnd_s1 <= bnd;
			last_s1 <= last_pt;
			idx_s1 <= idx_q;
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_count_q <= '0;
			emit_column_q <= '0;
			emit_row_q <= '0;
			wr_ptr_q <= '0;
			emit_ptr_q <= '0;
			idx_q <= '0;
			s1_valid_s1 <= 1'b0;
		end else begin
			if (fire) s1_valid_s1 <= emit;
			else if (job_ready) s1_valid_s1 <= 1'b0;
			if (fire) begin
				logic [brs_pkg::CntBits-1:0] cnt;
				logic [brs_pkg::AddrBits-1:0] wp, ep;
				logic [10:0] ec;
				logic [15:0] er;
				logic [brs_pkg::IdxBits-1:0] ix;
				cnt = wrap_rows ? '0 : input_count_q;
				wp  = wrap_rows ? '0 : wr_ptr_q;
				ep  = wrap_rows ? '0 : emit_ptr_q;
				ec  = wrap_rows ? '0 : emit_column_q;
				er  = wrap_rows ? '0 : emit_row_q;
				ix  = wrap_rows ? '0 : idx_q;
				if (wr) begin
					cnt = cnt + 1'b1;
					wp = (wp == depth - 1'b1) ? '0 : wp + 1'b1;
				end
				if (emit) begin
					if (last_pt) begin
						cnt = '0; ec = '0; er = '0; wp = '0; ep = '0; ix = '0;
					end else begin
						ep = (ep == depth - 1'b1) ? '0 : ep + 1'b1;
						ix = ix + 1'b1;
						ec = ec + 1'b1;
						if (ec >= w) begin ec = '0; er = er + 1'b1; end
					end
				end
				input_count_q <= cnt;
				wr_ptr_q <= wp;
				emit_ptr_q <= ep;
				emit_column_q <= ec;
				emit_row_q <= er;
				idx_q <= ix;
			end
		end
	end

	assign job_valid = s1_valid_s1;
	assign job = '{boundary: bnd_s1, last: last_s1, index: idx_s1, u: u_s1,
		ul: ul_s1, ur: ur_s1, ut: ut_s1, ub: ub_s1};

endmodule

// ===== src/brs_fifo.sv =====
// short job queue between front and back
module brs_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  brs_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output brs_pkg::job_t rd_data
);

	brs_pkg::job_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != 3'd4;
	assign rd_valid = cnt_q != 3'd0;
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

// ===== src/brs_back.sv =====
// computes the residual: laplacian terms plus source times exp(u), or u itself at boundary points
module brs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  brs_pkg::job_t       job,
	input  logic [30:0]         coef_h,
	input  logic [30:0]         coef_v,
	input  logic [30:0]         source,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         out_residual,
	output logic [brs_pkg::IdxBits-1:0] out_index,
	output logic                out_last
);

	localparam int Stages = 14;

	logic adv;
	logic [Stages-1:0] vld_q;
	logic [Stages-1:0] bnd_q, last_q, sat_hi_q, sat_lo_q;
	logic [brs_pkg::IdxBits-1:0] idx_q [Stages];
	logic signed [31:0] u_q [Stages];
	logic signed [63:0] lap_q [Stages];
	logic signed [63:0] k_q [Stages];
	logic signed [63:0] r_q [Stages];
	logic signed [63:0] p_q [Stages];
	logic signed [63:0] prod_q [Stages];

	assign adv = !out_valid || out_ready;
	assign job_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[Stages-2:0], job_valid};
	end

	// stage 0: laplacian, exp range and k; stage 1: r; 2..9: horner
	// (each stage multiplies and adds); then scaling, source, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [63:0] t, x;
			x = 64'(job.u);
			bnd_q[0] <= job.boundary;
			last_q[0] <= job.last;
			idx_q[0] <= job.index;
			u_q[0] <= job.u;
			lap_q[0] <= brs_pkg::scale_term(34'(job.ul) + 34'(job.ur) - 34'(job.u) * 2, coef_h)
				+ brs_pkg::scale_term(34'(job.ut) + 34'(job.ub) - 34'(job.u) * 2, coef_v);
			sat_hi_q[0] <= x >= (64'sd5 <<< 24);
			sat_lo_q[0] <= x < -(64'sd20 <<< 24);
			t = x * brs_pkg::Log2eQ30 + (64'sd1 <<< 53);
			k_q[0] <= t >>> 54;
			for (int i = 1; i < Stages; i++) begin
				bnd_q[i] <= bnd_q[i-1];
				last_q[i] <= last_q[i-1];
				idx_q[i] <= idx_q[i-1];
				u_q[i] <= u_q[i-1];
				lap_q[i] <= lap_q[i-1];
				sat_hi_q[i] <= sat_hi_q[i-1];
				sat_lo_q[i] <= sat_lo_q[i-1];
				k_q[i] <= k_q[i-1];
			end
			for (int i = 2; i < 9; i++) r_q[i] <= r_q[i-1];
			// r and seed of horner
			r_q[1] <= 64'(u_q[0]) * 64 - k_q[0] * brs_pkg::Ln2Q30;
			p_q[1] <= brs_pkg::inv_fact(4'd8);
			// horner: one coefficient per stage, p fits 33 bits and r 32 bits
			for (int j = 0; j < 8; j++) begin
				t = $signed(p_q[1+j][32:0]) * $signed(r_q[1+j][31:0]) + (64'sd1 <<< 29);
				p_q[2+j] <= brs_pkg::inv_fact(4'(7 - j)) + (t >>> 30);
			end
			// scale to q24
			begin
				logic [63:0] v, pp;
				logic signed [63:0] k;
				logic [6:0] s;
				pp = p_q[9][63] ? 64'd0 : 64'(p_q[9]);
				k = k_q[9];
				if (k >= 6) begin
					s = 7'(k - 6);
					v = (s > 7'd31) ? 64'hFFFF_FFFF : (pp << s);
					if (s > 7'd31 && pp == 0) v = 0;
				end else begin
					s = 7'(6 - k);
					v = (pp + (64'd1 << (s - 7'd1))) >> s;
				end
				if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
				if (sat_hi_q[9]) v = 64'h7FFF_FFFF;
				if (sat_lo_q[9]) v = 64'd0;
				prod_q[10] <= 64'(v);
			end
			prod_q[11] <= 64'((prod_q[10] * 64'(source) + (64'sd1 <<< 23)) >>> 24);
			begin
				logic signed [63:0] res;
				res = bnd_q[11] ? 64'(u_q[11]) : lap_q[11] + prod_q[11];
				if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
				if (res < -64'sh8000_0000) res = -64'sh8000_0000;
				prod_q[12] <= res;
			end
			prod_q[13] <= prod_q[12];
		end
	end

	assign out_valid = vld_q[Stages-1];
	assign out_residual = prod_q[Stages-1][31:0];
	assign out_index = idx_q[Stages-1];
	assign out_last = last_q[Stages-1];

endmodule

// ===== tb/sv/bratu_residual_stencil_core_test.sv =====
module bratu_residual_stencil_core_test;

	localparam int WatchLimit = 4000;
	localparam int TailCycles = 40;
	localparam longint ValMax = 64'sd2147483647;

	typedef struct {
		logic        kind;
		logic [31:0] value;
	} grid_item_t;

	typedef struct {
		logic [31:0] residual;
		logic [25:0] index;
		logic        last;
	} residual_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [30:0] cfg_data = '0;

	bratu_residual_stencil_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	grid_item_t pending_items[$];
	residual_t  expected_residuals[$];
	int  fails = 0;
	int  n_items = 0;
	int  n_results = 0;
	int  n_grids = 0;
	bit  quiet = 1'b0;
	bit  hold_req = 1'b0;

	// predictor state
	logic [31:0] line_store [0:brs_pkg::StoreDepth-1];
	int          fed_count = 0;
	int          out_col = 0;
	int          out_row = 0;
	logic [10:0] width_reg = 11'd4;
	logic [15:0] height_reg = 16'd4;
	logic [30:0] coef_h_reg = 31'd16777216;
	logic [30:0] coef_v_reg = 31'd16777216;
	logic [30:0] source_reg = 31'd11184811;

	function automatic longint recip_fact(input int n);
		case (n)
			0: return 64'sd1073741824;
			1: return 64'sd1073741824;
			2: return 64'sd536870912;
			3: return 64'sd178956971;
			4: return 64'sd44739243;
			5: return 64'sd8947849;
			6: return 64'sd1491308;
			7: return 64'sd213044;
			default: return 64'sd26631;
		endcase
	endfunction

	// table and polynomial exp, q24 in and out
	function automatic longint exp_approx(input longint x);
		longint k, r, p;
		longint unsigned v;
		int s;
		if (x >= (64'sd5 <<< 24)) return ValMax;
		if (x < -(64'sd20 <<< 24)) return 0;
		k = (x * 64'sd1549082005 + (64'sd1 <<< 53)) >>> 54;
		r = x * 64 - k * 64'sd744261118;
		p = recip_fact(8);
		for (int i = 7; i >= 0; i--)
			p = recip_fact(i) + ((p * r + (64'sd1 <<< 29)) >>> 30);
		if (p < 0) p = 0;
		if (k >= 6) begin
			v = longint'(p) << (k - 6);
		end else begin
			s = 6 - k;
			v = (longint'(p) + (64'd1 << (s - 1))) >> s;
		end
		if (v > ValMax) v = ValMax;
		return longint'(v);
	endfunction

	// difference times coefficient, rounded half away from zero
	function automatic longint scaled_diff(input longint d, input logic [30:0] c);
		logic [63:0] m;
		logic [64:0] q;
		m = (d < 0) ? -d : d;
		q = ({1'b0, m} * 65'(c) + 65'(64'd1 << 23)) >> 24;
		return (d < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic longint tap(input int a, input int depth);
		return longint'($signed(line_store[a % depth]));
	endfunction

	// advance the stencil state by one accepted transaction
	function automatic void predict_residual(input logic kind, input logic [31:0] value);
		int w, h, depth, total, p;
		bit emit, is_last;
		longint u, res;
		residual_t r;
		w = (width_reg < 3) ? 3 : (width_reg > brs_pkg::MaxWidth) ? brs_pkg::MaxWidth
			: int'(width_reg);
		h = (height_reg < 3) ? 3 : int'(height_reg);
		depth = 2 * w + 1;
		total = w * h;
		if (out_row >= h) begin
			fed_count = 0; out_row = 0; out_col = 0;
		end
		if (kind == brs_pkg::KindValue) begin
			if (fed_count >= total) return;
			emit = fed_count >= w + 1;
		end else begin
			if (fed_count < total) return;
			emit = 1'b1;
		end
		is_last = 1'b0;
		if (emit) begin
			p = out_row * w + out_col;
			u = tap(p, depth);
			if (out_col == 0 || out_row == 0 || out_col >= w - 1 || out_row >= h - 1) begin
				res = u;
			end else begin
				res = scaled_diff(tap(p + depth - 1, depth) + tap(p + 1, depth) - 2 * u,
					coef_h_reg)
					+ scaled_diff(tap(p + w, depth) + tap(p + depth - w, depth) - 2 * u,
					coef_v_reg)
					+ longint'((longint'(source_reg) * exp_approx(u) + (64'sd1 <<< 23)) >>> 24);
			end
			if (res > ValMax) res = ValMax;
			if (res < -ValMax - 1) res = -ValMax - 1;
			is_last = (out_row == h - 1) && (out_col == w - 1);
			r.residual = res[31:0];
			r.index = p[25:0];
			r.last = is_last;
			expected_residuals.push_back(r);
		end
		if (kind == brs_pkg::KindValue) begin
			line_store[fed_count % depth] = value;
			fed_count++;
		end
		if (emit) begin
			if (is_last) begin
				fed_count = 0; out_row = 0; out_col = 0;
			end else begin
				out_col++;
				if (out_col >= w) begin
					out_col = 0; out_row++;
				end
			end
		end
	endfunction

	// driver: feeds pending items, random gaps
	int send_gap = 0;
	always @(posedge clk) begin
		grid_item_t it;
		if (s_axis_tvalid && s_axis_tready) begin
			predict_residual(s_axis_tuser, s_axis_tdata);
			n_items++;
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap == 0 && !quiet && $urandom_range(0, 14) == 0)
				send_gap = $urandom_range(1, 18);
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= it.kind;
				s_axis_tdata <= it.value;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor: random stalls, one long hold, checks each result transaction
	int recv_gap = 0;
	always @(posedge clk) begin
		residual_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (expected_residuals.size() == 0) begin
				$display("%0t unexpected result: got %h last %b", $time, m_axis_tdata,
					m_axis_tlast);
				fails++;
			end else begin
				e = expected_residuals.pop_front();
				if (m_axis_tdata[31:0] !== e.residual) begin
					$display("%0t residual mismatch: expected %h actual %h", $time,
						e.residual, m_axis_tdata[31:0]);
					fails++;
				end
				if (m_axis_tdata[57:32] !== e.index) begin
					$display("%0t point index mismatch: expected %0d actual %0d", $time,
						e.index, m_axis_tdata[57:32]);
					fails++;
				end
				if (m_axis_tlast !== e.last) begin
					$display("%0t last mismatch: expected %b actual %b", $time, e.last,
						m_axis_tlast);
					fails++;
				end
			end
		end
		if (hold_req) begin
			hold_req = 1'b0;
			recv_gap = 300;
		end else if (recv_gap == 0 && !quiet && $urandom_range(0, 12) == 0) begin
			recv_gap = $urandom_range(1, 18);
		end
		if (recv_gap > 0) begin
			recv_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n;
		end
	end

	// watchdog on cycles without any transaction
	int stuck = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stuck = 0;
		else if (arst_n)
			stuck++;
		if (stuck >= WatchLimit) begin
			$display("timeout with %0d results outstanding", expected_residuals.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			brs_pkg::RegWidth:  width_reg = val[10:0];
			brs_pkg::RegHeight: height_reg = val[15:0];
			brs_pkg::RegCoefH:  coef_h_reg = val;
			brs_pkg::RegCoefV:  coef_v_reg = val;
			brs_pkg::RegSource: source_reg = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_item(input logic kind, input logic [31:0] value);
		grid_item_t it;
		it.kind = kind;
		it.value = value;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 3))
			0, 1: return $urandom();
			2: return 32'($signed($urandom_range(0, 25 << 24)) - (20 <<< 24));
			default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 <<< 25));
		endcase
	endfunction

	function automatic logic [30:0] rand_coef();
		case ($urandom_range(0, 4))
			0: return 31'd0;
			1: return 31'h7FFFFFFF;
			2: return 31'($urandom());
			default: return 31'($urandom_range(0, 1 << 26));
		endcase
	endfunction

	// one grid with optional noise, then the flush ticks that drain it
	task automatic queue_grid(input int w, input int h, input bit noise);
		for (int i = 0; i < w * h; i++) begin
			if (noise && $urandom_range(0, 9) == 0) push_item(brs_pkg::KindFlush, $urandom());
			push_item(brs_pkg::KindValue, rand_value());
		end
		if (noise)
			repeat ($urandom_range(0, 3)) push_item(brs_pkg::KindValue, $urandom());
		for (int i = 0; i < w + 1; i++) push_item(brs_pkg::KindFlush, $urandom());
		n_grids++;
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || s_axis_tvalid || expected_residuals.size() > 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	initial begin
		int w, h;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default 4x4 grid with format extremes and exp range edges
		push_item(brs_pkg::KindFlush, 32'hFFFFFFFF);
		push_item(brs_pkg::KindValue, 32'h80000000);
		push_item(brs_pkg::KindValue, 32'h7FFFFFFF);
		push_item(brs_pkg::KindValue, 32'h00000000);
		push_item(brs_pkg::KindValue, 32'h05000000);
		push_item(brs_pkg::KindValue, 32'h00FFFFFF);
		push_item(brs_pkg::KindValue, 32'h04FFFFFF);
		push_item(brs_pkg::KindValue, 32'h05000000);
		push_item(brs_pkg::KindValue, 32'hEC000000);
		push_item(brs_pkg::KindValue, 32'hFFFFFFFF);
		push_item(brs_pkg::KindValue, 32'hEBFFFFFF);
		push_item(brs_pkg::KindValue, 32'hEC000000);
		push_item(brs_pkg::KindValue, 32'h01000000);
		push_item(brs_pkg::KindValue, 32'h7FFFFFFF);
		push_item(brs_pkg::KindValue, 32'h80000000);
		push_item(brs_pkg::KindFlush, 32'h0);
		push_item(brs_pkg::KindValue, 32'h55555555);
		push_item(brs_pkg::KindValue, 32'hAAAAAAAA);
		push_item(brs_pkg::KindValue, 32'h12345678);
		for (int i = 0; i < 5; i++) push_item(brs_pkg::KindFlush, 32'h0);
		n_grids++;
		wait_drained();

		// clamped minimum sizes, extreme coefficients
		write_reg(brs_pkg::RegWidth, 31'd0);
		write_reg(brs_pkg::RegHeight, 31'd2);
		write_reg(brs_pkg::RegCoefH, 31'd0);
		write_reg(brs_pkg::RegCoefV, 31'd0);
		write_reg(brs_pkg::RegSource, 31'h7FFFFFFF);
		write_reg(3'd5, 31'h7FFFFFFF);
		write_reg(3'd7, 31'd1);
		queue_grid(3, 3, 1'b1);
		wait_drained();

		// wider row, long receiver hold while the sender keeps offering
		write_reg(brs_pkg::RegWidth, 31'd40);
		write_reg(brs_pkg::RegHeight, 31'd0);
		write_reg(brs_pkg::RegCoefH, 31'h7FFFFFFF);
		write_reg(brs_pkg::RegCoefV, 31'h7FFFFFFF);
		write_reg(brs_pkg::RegSource, 31'd0);
		queue_grid(40, 3, 1'b0);
		while (n_results < 30) @(posedge clk);
		hold_req = 1'b1;
		wait_drained();

		// random small grids
		while (n_items < 480) begin
			w = $urandom_range(3, 9);
			h = $urandom_range(3, 8);
			write_reg(brs_pkg::RegWidth, 31'(w));
			write_reg(brs_pkg::RegHeight, 31'(h));
			write_reg(brs_pkg::RegCoefH, rand_coef());
			write_reg(brs_pkg::RegCoefV, rand_coef());
			write_reg(brs_pkg::RegSource, rand_coef());
			queue_grid(w, h, 1'b1);
			wait_drained();
		end

		// a tall narrow grid and a small one, without random gaps or stalls
		quiet = 1'b1;
		write_reg(brs_pkg::RegWidth, 31'd3);
		write_reg(brs_pkg::RegHeight, 31'd20);
		write_reg(brs_pkg::RegCoefH, rand_coef());
		write_reg(brs_pkg::RegCoefV, rand_coef());
		write_reg(brs_pkg::RegSource, 31'd11184811);
		queue_grid(3, 20, 1'b0);
		wait_drained();
		write_reg(brs_pkg::RegWidth, 31'd5);
		write_reg(brs_pkg::RegHeight, 31'd4);
		queue_grid(5, 4, 1'b1);
		wait_drained();

		$display("covered %0d grids, %0d input transactions, %0d result transactions",
			n_grids, n_items, n_results);
		$display("sizes from clamped 3x3 to 40 wide and 20 tall, with stalls and noise");
		if (fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
